// ----- hdl/pcg_pkg.sv -----
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types and constants for the polar curve CV generator.
// ----------------------------------------------------------------------------
package pcg_pkg;

	localparam int PHASE_BITS_DEF = 32;
	localparam int OUT_BITS_DEF   = 16;

	// configuration register indexes
	localparam logic [3:0] REG_A_COEF = 4'd0;
	localparam logic [3:0] REG_B_COEF = 4'd1;
	localparam logic [3:0] REG_SPEED  = 4'd2;
	localparam logic [3:0] REG_FAST   = 4'd3;

	localparam logic [14:0] SPEED_RST    = 15'd107;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [8:0]  IND_LIMIT    = 9'd300;

	// 2^15/pi in Q16, split into upper and lower 16-bit halves
	localparam logic [15:0] RAD_K_HI = 16'd10430;
	localparam logic [15:0] RAD_K_LO = 16'd24796;

	// sine polynomial coefficients
	localparam logic [15:0] SIN_C1 = 16'd51472;
	localparam logic [15:0] SIN_C3 = 16'd21024;
	localparam logic [15:0] SIN_C5 = 16'd2320;

	// operand pair for the shared multiplier
	typedef struct packed {
		logic [19:0] op_a;
		logic [15:0] op_b;
	} mul_req_t;

	// Q15 value in sign/magnitude form
	typedef struct packed {
		logic        neg;
		logic [14:0] mag;
	} sin_res_t;

endpackage

// ----- hdl/pcg_if.sv -----
// ----------------------------------------------------------------------------
// pcg_if
// Valid/ready channels of the polar curve CV generator.
// ----------------------------------------------------------------------------
interface pcg_in_if;
	logic valid;
	logic ready;
	logic trig_switch_on;
	modport source (output valid, output trig_switch_on, input ready);
	modport sink   (input valid, input trig_switch_on, output ready);
endinterface

interface pcg_out_if #(parameter int OUT_BITS = 16);
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] x_out;
	logic signed [OUT_BITS-1:0] y_out;
	logic [1:0]                 equation_sel;
	logic                       indicator_on;
	modport source (output valid, output x_out, output y_out, output equation_sel,
		output indicator_on, input ready);
	modport sink   (input valid, input x_out, input y_out, input equation_sel,
		input indicator_on, output ready);
endinterface

interface pcg_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [14:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/polar_curve_cv_generator.sv -----
// ----------------------------------------------------------------------------
// polar_curve_cv_generator
// Polar rose curve control-voltage generator: x/y from the stored cursor,
// then phase advance and radius of the selected curve equation.
// ----------------------------------------------------------------------------
// Flow: x and y are registered into the output register in ST_OUT; a new
//   input transaction is accepted only in ST_IDLE, once the radius update
//   (ST_R1 to ST_W_R for equations 1 and 2, ST_W_A and ST_M_R for 0 and 3) is
//   done; sines use one sine sequencer, all sines and products one multiplier.
//   A result still held by the receiver stalls the next one in ST_OUT.
// Reset: arst_n clears phase, radius, equation, switch history, counter and
//   sets the registers to a=0, b=0, speed=107, fast=0. No clearing pass.
module polar_curve_cv_generator import pcg_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF,
	parameter int OUT_BITS   = OUT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pcg_in_if.sink     in_ch,
	pcg_out_if.source  out_ch,
	pcg_cfg_if.sink    cfg_ch
);
	localparam int PW = PHASE_BITS + 19;

	// sequencer codes
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_W_SX = 4'd1;  // wait sin of 2*phase
	localparam logic [3:0] ST_M_X  = 4'd2;  // x product ready
	localparam logic [3:0] ST_W_SY = 4'd3;  // wait cos of 2*phase
	localparam logic [3:0] ST_M_Y  = 4'd4;
	localparam logic [3:0] ST_OUT  = 4'd5;  // hand result over, step phase
	localparam logic [3:0] ST_TB   = 4'd6;
	localparam logic [3:0] ST_W_C  = 4'd7;  // wait cos(B theta)
	localparam logic [3:0] ST_R1   = 4'd8;  // A*|c| ready
	localparam logic [3:0] ST_R2   = 4'd9;
	localparam logic [3:0] ST_R3   = 4'd10;
	localparam logic [3:0] ST_W_R  = 4'd11; // wait sin/cos(A cos(B theta))
	localparam logic [3:0] ST_W_A  = 4'd12; // wait sin(A theta)
	localparam logic [3:0] ST_M_R  = 4'd13;

	// configuration
	logic [4:0]  a_coef_q;
	logic [4:0]  b_coef_q;
	logic [14:0] speed_q;
	logic        fast_q;

	// block state
	logic [3:0]            state_q;
	logic [PHASE_BITS-1:0] phase_q;
	sin_res_t              radius_q;
	logic [1:0]            equation_q;
	logic                  prev_sw_q;
	logic [8:0]            ind_cnt_q;
	logic                  ind_q;

	// working registers
	logic [31:0] ang_q;
	logic        go_q;
	sin_res_t    x_q;
	sin_res_t    y_q;
	sin_res_t    c_q;
	sin_res_t    s_q;
	logic [19:0] am_q;
	logic [33:0] hi_q;

	// output register
	logic                       out_valid_q;
	logic signed [OUT_BITS-1:0] x_out_q;
	logic signed [OUT_BITS-1:0] y_out_q;
	logic [1:0]                 eq_out_q;
	logic                       ind_out_q;

	// shared units
	mul_req_t    sin_req;
	mul_req_t    top_req;
	mul_req_t    mul_req;
	logic [35:0] prod;
	logic        sin_done;
	sin_res_t    sin_res;

	logic [31:0] turn2;
	logic [31:0] turn_a;
	logic [31:0] turn_b;
	logic [18:0] delta;
	logic [31:0] u_mag;
	logic [31:0] u_turn;
	logic        in_acc;
	logic        sw_chg;

	// turn of k*phase: low PHASE_BITS of the product, aligned to 32 bits
	function automatic logic [31:0] turn_of(input logic [4:0] k,
		input logic [PHASE_BITS-1:0] ph);
		logic [PHASE_BITS-1:0] kp;
		logic [PHASE_BITS+31:0] ext;
		kp  = PHASE_BITS'(PW'(k) * PW'(ph));
		ext = {kp, 32'd0};
		return ext[PHASE_BITS+31 -: 32];
	endfunction

	// sign/magnitude Q15 to OUT_BITS two's complement
	function automatic logic [OUT_BITS-1:0] to_out(input sin_res_t v);
		logic [OUT_BITS+15:0] ext;
		logic [OUT_BITS-1:0]  m;
		ext = {16'(v.mag), OUT_BITS'(0)};
		m   = ext[OUT_BITS+15 -: OUT_BITS];
		return v.neg ? (OUT_BITS'(0) - m) : m;
	endfunction

	assign turn2  = turn_of(5'd2, phase_q);
	assign turn_a = turn_of(a_coef_q, phase_q);
	assign turn_b = turn_of(b_coef_q, phase_q);
	assign delta  = fast_q ? ({1'b0, speed_q, 3'b000} + {3'b000, speed_q, 1'b0})
		: {4'd0, speed_q};

	// radian to turn: (am*K)>>16 = am*K_HI + (am*K_LO)>>16
	assign u_mag  = 32'(hi_q + 34'(prod[35:16]));
	assign u_turn = (c_q.neg ? (32'd0 - u_mag) : u_mag)
		+ ((equation_q == 2'd2) ? QUARTER_TURN : 32'd0);

	assign in_acc = in_ch.valid && in_ch.ready;
	assign sw_chg = in_ch.trig_switch_on != prev_sw_q;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;

	pcg_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	pcg_sine u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.angle  (ang_q),
		.prod   (prod),
		.req    (sin_req),
		.done   (sin_done),
		.res    (sin_res)
	);

	// the sine sequencer owns the multiplier except in the top's product steps
	always_comb begin
		top_req = '0;
		case (state_q)
			ST_W_SX, ST_W_SY: begin
				top_req.op_a = 20'(radius_q.mag);
				top_req.op_b = 16'(sin_res.mag);
			end
			ST_W_C: begin
				top_req.op_a = 20'(a_coef_q);
				top_req.op_b = 16'(sin_res.mag);
			end
			ST_R1: begin
				top_req.op_a = prod[19:0];
				top_req.op_b = RAD_K_HI;
			end
			ST_R2: begin
				top_req.op_a = am_q;
				top_req.op_b = RAD_K_LO;
			end
			ST_W_A: begin
				top_req.op_a = 20'(sin_res.mag);
				top_req.op_b = 16'(c_q.mag);
			end
			default: top_req = '0;
		endcase
		mul_req = sin_done ? top_req : ((state_q == ST_R1 || state_q == ST_R2)
			? top_req : sin_req);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_coef_q <= '0;
			b_coef_q <= '0;
			speed_q  <= SPEED_RST;
			fast_q   <= 1'b0;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				REG_A_COEF: a_coef_q <= cfg_ch.data[4:0];
				REG_B_COEF: b_coef_q <= cfg_ch.data[4:0];
				REG_SPEED:  speed_q  <= cfg_ch.data;
				REG_FAST:   fast_q   <= cfg_ch.data[0];
				default:    ;
			endcase
		end
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			radius_q    <= '0;
			equation_q  <= '0;
			prev_sw_q   <= 1'b0;
			ind_cnt_q   <= '0;
			ind_q       <= 1'b0;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						// switch edge: next equation, indicator restarts
						if (sw_chg) begin
							equation_q <= equation_q + 2'd1;
							ind_q      <= 1'b1;
							ind_cnt_q  <= 9'd1;
						end else begin
							ind_q <= ind_cnt_q < IND_LIMIT;
							if (ind_cnt_q < IND_LIMIT) ind_cnt_q <= ind_cnt_q + 9'd1;
						end
						prev_sw_q <= in_ch.trig_switch_on;
						ang_q     <= turn2;
						go_q      <= 1'b1;
						state_q   <= ST_W_SX;
					end
				end
				ST_W_SX: if (sin_done) state_q <= ST_M_X;
				ST_M_X: begin
					x_q.mag <= prod[29:15];
					x_q.neg <= radius_q.neg ^ s_q.neg;
					ang_q   <= turn2 + QUARTER_TURN;
					go_q    <= 1'b1;
					state_q <= ST_W_SY;
				end
				ST_W_SY: if (sin_done) state_q <= ST_M_Y;
				ST_M_Y: begin
					y_q.mag <= prod[29:15];
					y_q.neg <= radius_q.neg ^ s_q.neg;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						phase_q     <= PHASE_BITS'(PW'(phase_q) + PW'(delta));
						state_q     <= ST_TB;
					end
				end
				ST_TB: begin
					ang_q   <= turn_b + QUARTER_TURN;
					go_q    <= 1'b1;
					state_q <= ST_W_C;
				end
				ST_W_C: begin
					if (sin_done) begin
						if (equation_q == 2'd1 || equation_q == 2'd2) begin
							state_q <= ST_R1;
						end else begin
							ang_q   <= turn_a;
							go_q    <= 1'b1;
							state_q <= ST_W_A;
						end
					end
				end
				ST_R1: state_q <= ST_R2;
				ST_R2: state_q <= ST_R3;
				ST_R3: begin
					ang_q   <= u_turn;
					go_q    <= 1'b1;
					state_q <= ST_W_R;
				end
				ST_W_R: begin
					if (sin_done) begin
						radius_q <= sin_res;
						state_q  <= ST_IDLE;
					end
				end
				ST_W_A: if (sin_done) state_q <= ST_M_R;
				ST_M_R: begin
					radius_q.mag <= prod[29:15];
					radius_q.neg <= s_q.neg ^ c_q.neg;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working payload registers
	always_ff @(posedge clk) begin
		if (sin_done) s_q <= sin_res;
		if (state_q == ST_W_C && sin_done) c_q <= sin_res;
		if (state_q == ST_R1) am_q <= prod[19:0];
		if (state_q == ST_R2) hi_q <= prod[33:0];
		if (state_q == ST_OUT && !out_valid_q) begin
			x_out_q   <= to_out(x_q);
			y_out_q   <= to_out(y_q);
			eq_out_q  <= equation_q;
			ind_out_q <= ind_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.x_out        = x_out_q;
	assign out_ch.y_out        = y_out_q;
	assign out_ch.equation_sel = eq_out_q;
	assign out_ch.indicator_on = ind_out_q;
endmodule

// ----- hdl/pcg_mul.sv -----
// ----------------------------------------------------------------------------
// pcg_mul
// Shared unsigned 20x16 multiplier with registered product.
// ----------------------------------------------------------------------------
module pcg_mul import pcg_pkg::*; (
	input  logic        clk,
	input  mul_req_t    req,
	output logic [35:0] prod
);
	logic [35:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= 36'(req.op_a) * 36'(req.op_b);
	end

	assign prod = prod_q;
endmodule

// ----- hdl/pcg_sine.sv -----
// ----------------------------------------------------------------------------
// pcg_sine
// Quarter-wave polynomial sine, evaluated over several cycles on the
// shared multiplier.
// ----------------------------------------------------------------------------
module pcg_sine import pcg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] angle,
	input  logic [35:0] prod,
	output mul_req_t    req,
	output logic        done,
	output sin_res_t    res
);
	localparam logic [2:0] SN_IDLE = 3'd0;
	localparam logic [2:0] SN_SQ   = 3'd1;
	localparam logic [2:0] SN_X2   = 3'd2;
	localparam logic [2:0] SN_T1   = 3'd3;
	localparam logic [2:0] SN_T2   = 3'd4;
	localparam logic [2:0] SN_Y    = 3'd5;

	logic [2:0]  state_q;
	logic [15:0] x_q;
	logic [15:0] x2_q;
	logic        neg_q;
	logic        done_q;
	sin_res_t    res_q;
	logic [15:0] x_in;

	// mirror the position in odd quadrants
	assign x_in = angle[30] ? (16'd32768 - {1'b0, angle[29:15]}) : {1'b0, angle[29:15]};

	always_comb begin
		req = '0;
		case (state_q)
			SN_SQ: begin
				req.op_a = 20'(x_q);
				req.op_b = x_q;
			end
			SN_X2: begin
				req.op_a = 20'(SIN_C5);
				req.op_b = prod[30:15];
			end
			SN_T1: begin
				req.op_a = 20'(SIN_C3 - prod[30:15]);
				req.op_b = x2_q;
			end
			SN_T2: begin
				req.op_a = 20'(SIN_C1 - prod[30:15]);
				req.op_b = x_q;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SN_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				SN_IDLE: if (start) state_q <= SN_SQ;
				SN_SQ:   state_q <= SN_X2;
				SN_X2:   state_q <= SN_T1;
				SN_T1:   state_q <= SN_T2;
				SN_T2:   state_q <= SN_Y;
				SN_Y: begin
					state_q <= SN_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= SN_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SN_IDLE && start) begin
			x_q   <= x_in;
			neg_q <= angle[31];
		end
		if (state_q == SN_X2) x2_q <= prod[30:15];
		if (state_q == SN_Y) begin
			res_q.neg <= neg_q;
			res_q.mag <= prod[30] ? 15'h7FFF : prod[29:15];
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule
